// File: rtl/core/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the HCI event filter RTL.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/hccf_pkg.sv
// -----------------------------------------------------------------------------
// hccf_pkg
// Types and constants shared by the HCI Command Complete filter modules.
// -----------------------------------------------------------------------------
package hccf_pkg;

  // Request function codes
  localparam logic [1:0] FUNC_BYTE    = 2'd0;
  localparam logic [1:0] FUNC_GAP     = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  // HCI framing constants
  localparam logic [7:0] PKT_TYPE_EVENT   = 8'h04;
  localparam logic [7:0] EVT_CMD_COMPLETE = 8'h0E;
  localparam logic [7:0] CC_MIN_LEN       = 8'd4;
  localparam logic [7:0] RP_OFFSET        = 8'd3;
  localparam logic [7:0] PCOUNT_MAX       = 8'd63;

  // Longest return parameter run copied out
  localparam int         RETURN_MAX = 32;
  localparam logic [7:0] COPY_MAX   = (RETURN_MAX < 32) ? 8'(RETURN_MAX) : 8'd32;

  // Input request
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
  } item_t;

  // Output result
  typedef struct packed {
    logic [7:0]  status;
    logic [7:0]  param_byte;
    logic [4:0]  param_index;
    logic [5:0]  param_count;
    logic [31:0] frame_count;
    logic        last;
  } result_t;

  // Run descriptor passed from parser to emitter
  typedef struct packed {
    logic [7:0]  status;
    logic [5:0]  param_count;
    logic [4:0]  copy_m1;
    logic [31:0] frame_count;
  } run_t;

endpackage

// File: rtl/core/hci_command_complete_filter.sv
// The first result of a run is valid after the final frame byte passes the run queue,
//   the payload RAM registered read and the output register. Requests are taken one per
//   cycle while cmd_stall is low; each later result is read when the prior one is taken.
// While a run drains, requests stall unless the parser is waiting for restart.
// Reset: rst is synchronous, active high; clears parser, counter, opcode and queue;
//   the payload RAM is not cleared.
// -----------------------------------------------------------------------------
// hci_command_complete_filter
// Parses HCI event frames from UART bytes and emits the return parameters of
// the Command Complete event that carries the configured opcode.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module hci_command_complete_filter #(
  parameter int PAYLOAD_MAX = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data,
  input  logic              cmd_valid,
  input  hccf_pkg::item_t   cmd,
  output logic              cmd_stall,
  output logic              res_valid,
  output hccf_pkg::result_t res,
  input  logic              res_stall
);

  localparam int AW = $clog2(PAYLOAD_MAX);

  logic           pending;
  logic           push;
  hccf_pkg::run_t push_run;
  logic           q_valid;
  hccf_pkg::run_t q_head;
  logic           q_pop;
  logic           back_busy;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [7:0]     ram_wdata;
  logic           ram_re;
  logic [AW-1:0]  ram_raddr;
  logic [7:0]     ram_rdata;

  // A run is in flight from push until its last result is taken
  assign pending = q_valid || back_busy;

  hccf_front #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_stall (cmd_stall),
    .pending   (pending),
    .push      (push),
    .run       (push_run),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  hccf_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_MAX)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hccf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_run (push_run),
    .valid    (q_valid),
    .head     (q_head),
    .pop      (q_pop)
  );

  hccf_back #(
    .ADDR_W (AW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .busy      (back_busy),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_stall (res_stall)
  );

  // The parser never overwrites the payload store while a run reads it
  `ASSERT_CLK(a_no_write_during_run, ram_we |-> !pending, "payload written during a run")
  `ASSERT_ALWAYS(a_reset_idle, rst |=> (!q_valid && !back_busy), "run state not cleared by reset")

endmodule

// File: rtl/core/hccf_ram.sv
// -----------------------------------------------------------------------------
// hccf_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module hccf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/hccf_front.sv
// -----------------------------------------------------------------------------
// hccf_front
// Event parser: hunts for event packets, stores payload, detects the match.
// -----------------------------------------------------------------------------
module hccf_front #(
  parameter int PAYLOAD_MAX = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [15:0]                    cfg_data,
  input  logic                           cmd_valid,
  input  hccf_pkg::item_t                cmd,
  output logic                           cmd_stall,
  input  logic                           pending,
  output logic                           push,
  output hccf_pkg::run_t                 run,
  output logic                           ram_we,
  output logic [$clog2(PAYLOAD_MAX)-1:0] ram_waddr,
  output logic [7:0]                     ram_wdata
);

  localparam int         AW   = $clog2(PAYLOAD_MAX);
  localparam logic [7:0] PMAX = 8'(PAYLOAD_MAX);

  typedef enum logic [5:0] {
    PH_HUNT    = 6'b000001,
    PH_EVENT   = 6'b000010,
    PH_LENGTH  = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_SKIP    = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_t;

  phase_t      phase;
  logic [15:0] expected_opcode;
  logic [7:0]  evt_code;
  logic [7:0]  length;
  logic [7:0]  byte_counter;
  logic [31:0] frame_total;
  logic [7:0]  op_lo;
  logic [7:0]  op_hi;
  logic [7:0]  status_byte;

  logic        accept;
  logic        is_byte;
  logic [7:0]  cnt_inc;
  logic        finish_zero;
  logic        finish_pay;
  logic        frame_done;
  logic        match;
  logic [7:0]  rp_len;
  logic [7:0]  copy_len;

  // Hold off new requests while a run drains, unless waiting for restart
  assign cmd_stall = pending && (phase != PH_DONE);
  assign accept    = cmd_valid && !cmd_stall;
  assign is_byte   = accept && (cmd.func == hccf_pkg::FUNC_BYTE) && (phase != PH_DONE);
  assign cnt_inc   = byte_counter + 8'd1;

  // Frame completion and Command Complete match
  assign finish_zero = is_byte && (phase == PH_LENGTH) && (cmd.rx_byte == 8'd0);
  assign finish_pay  = is_byte && (phase == PH_PAYLOAD) && (cnt_inc >= length);
  assign frame_done  = finish_zero || finish_pay;
  assign match       = finish_pay && (evt_code == hccf_pkg::EVT_CMD_COMPLETE) &&
                       (length >= hccf_pkg::CC_MIN_LEN) &&
                       ({op_hi, op_lo} == expected_opcode);

  // Payload store write
  assign ram_we    = is_byte && (phase == PH_PAYLOAD) && (byte_counter < PMAX);
  assign ram_waddr = byte_counter[AW-1:0];
  assign ram_wdata = cmd.rx_byte;

  // Run descriptor; status may arrive as the final byte
  assign rp_len   = length - hccf_pkg::RP_OFFSET;
  assign copy_len = (rp_len > hccf_pkg::COPY_MAX) ? hccf_pkg::COPY_MAX : rp_len;
  assign push     = match;

  always_comb begin
    run.status      = (byte_counter == 8'd3) ? cmd.rx_byte : status_byte;
    run.param_count = (rp_len > hccf_pkg::PCOUNT_MAX) ? 6'(hccf_pkg::PCOUNT_MAX)
                                                      : rp_len[5:0];
    run.copy_m1     = 5'(copy_len - 8'd1);
    run.frame_count = frame_total + 32'd1;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_opcode <= 16'd0;
    end else if (cfg_we) begin
      expected_opcode <= cfg_data;
    end
  end

  // Frame counter
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_total <= 32'd0;
    end else if (frame_done) begin
      frame_total <= frame_total + 32'd1;
    end
  end

  // Opcode and status capture, fixed payload positions
  always_ff @(posedge clk) begin
    if (ram_we) begin
      if (byte_counter == 8'd1) begin
        op_lo <= cmd.rx_byte;
      end
      if (byte_counter == 8'd2) begin
        op_hi <= cmd.rx_byte;
      end
      if (byte_counter == 8'd3) begin
        status_byte <= cmd.rx_byte;
      end
    end
  end

  // Parser state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      evt_code     <= 8'd0;
      length       <= 8'd0;
      byte_counter <= 8'd0;
    end else if (accept) begin
      if (cmd.func == hccf_pkg::FUNC_RESTART) begin
        phase        <= PH_HUNT;
        byte_counter <= 8'd0;
      end else if (phase == PH_DONE) begin
        phase <= PH_DONE;
      end else if (cmd.func == hccf_pkg::FUNC_GAP) begin
        phase <= PH_HUNT;
      end else if (cmd.func == hccf_pkg::FUNC_BYTE) begin
        case (phase)
          PH_HUNT: begin
            if (cmd.rx_byte == hccf_pkg::PKT_TYPE_EVENT) begin
              phase <= PH_EVENT;
            end
          end
          PH_EVENT: begin
            evt_code <= cmd.rx_byte;
            phase    <= PH_LENGTH;
          end
          PH_LENGTH: begin
            length       <= cmd.rx_byte;
            byte_counter <= 8'd0;
            if (cmd.rx_byte > PMAX) begin
              phase <= PH_SKIP;
            end else if (cmd.rx_byte == 8'd0) begin
              phase <= PH_HUNT;
            end else begin
              phase <= PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            byte_counter <= cnt_inc;
            if (finish_pay) begin
              phase <= match ? PH_DONE : PH_HUNT;
            end
          end
          PH_SKIP: begin
            byte_counter <= cnt_inc;
            if (cnt_inc >= length) begin
              phase <= PH_HUNT;
            end
          end
          default: begin
            phase <= PH_HUNT;
          end
        endcase
      end
    end
  end

endmodule

// File: rtl/core/hccf_queue.sv
// -----------------------------------------------------------------------------
// hccf_queue
// One-entry run descriptor queue between parser and emitter.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module hccf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hccf_pkg::run_t push_run,
  output logic           valid,
  output hccf_pkg::run_t head,
  input  logic           pop
);

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (pop) begin
      valid <= 1'b0;
    end
  end

  // Descriptor storage
  always_ff @(posedge clk) begin
    if (push) begin
      head <= push_run;
    end
  end

  `ASSERT_CLK(a_no_overflow, push |-> !valid, "run queue overflow")
  `ASSERT_CLK(a_no_underflow, pop |-> valid, "run queue underflow")
  `ASSERT_CLK(a_push_lands, push |=> valid, "pushed run descriptor lost")

endmodule

// File: rtl/core/hccf_back.sv
// -----------------------------------------------------------------------------
// hccf_back
// Result emitter: reads return parameters from the payload store, one a time.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module hccf_back #(
  parameter int ADDR_W = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  hccf_pkg::run_t      q_head,
  output logic                q_pop,
  output logic                busy,
  output logic                ram_re,
  output logic [ADDR_W-1:0]   ram_raddr,
  input  logic [7:0]          ram_rdata,
  output logic                res_valid,
  output hccf_pkg::result_t   res,
  input  logic                res_stall
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WAIT = 3'b010,
    ST_SEND = 3'b100
  } state_t;

  state_t         state;
  hccf_pkg::run_t cur;
  logic [4:0]     k;
  logic           res_take;
  logic           more;
  logic [4:0]     k_sel;

  assign busy      = (state != ST_IDLE);
  assign res_valid = (state == ST_SEND);
  assign res_take  = res_valid && !res_stall;
  assign more      = res_take && !res.last;
  assign q_pop     = (state == ST_IDLE) && q_valid;

  // Read address: first parameter on pop, next one on each taken result but the last
  assign k_sel     = (state == ST_IDLE) ? 5'd0 : (k + 5'd1);
  assign ram_re    = q_pop || more;
  assign ram_raddr = ADDR_W'(hccf_pkg::RP_OFFSET + {3'b000, k_sel});

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          state <= ST_SEND;
        end
        ST_SEND: begin
          if (more) begin
            state <= ST_WAIT;
          end else if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Run context and parameter index
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (ram_re) begin
      k <= k_sel;
    end
  end

  // Output register, loaded when read data lands
  always_ff @(posedge clk) begin
    if (state == ST_WAIT) begin
      res.status      <= cur.status;
      res.param_byte  <= ram_rdata;
      res.param_index <= k;
      res.param_count <= cur.param_count;
      res.frame_count <= cur.frame_count;
      res.last        <= (k == cur.copy_m1);
    end
  end

  `ASSERT_CLK(a_index_steps, more |=> ##1
    (res_valid && (res.param_index == ($past(res.param_index, 2) + 5'd1))),
    "return parameter index did not advance by one")

endmodule
